[rtl/greedy_point_merge_assert.svh]
// ----------------------------------------------------------------------------
// greedy_point_merge assertion macros
// Concurrent checks, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef GREEDY_POINT_MERGE_ASSERT_SVH
`define GREEDY_POINT_MERGE_ASSERT_SVH
`ifndef ASSERT_OFF
`define GPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("greedy_point_merge assertion failed");
`define GPM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("greedy_point_merge assertion failed");
`else
`define GPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GPM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/gpm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpm_pkg
// Shared constants of the greedy point merge block.
// ----------------------------------------------------------------------------
package gpm_pkg;
    localparam int MINC_W = 6;
    localparam int RAD_W  = 12;
    localparam int CIDX_W = 2;
    localparam int CFG_W  = 12;

    localparam logic [CIDX_W-1:0] REG_MIN_COUNT = 2'd0;
    localparam logic [CIDX_W-1:0] REG_RADIUS    = 2'd1;
    localparam logic [CIDX_W-1:0] REG_PRESORTED = 2'd2;

    typedef struct packed {
        logic en;
    } t_sq_ctl;
endpackage

[rtl/gpm_sqdiff.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpm_sqdiff
// Shared unit: registered square of an absolute difference.
// ----------------------------------------------------------------------------
module gpm_sqdiff #(
    parameter int W = 12
) (
    input  logic             i_clk,
    input  gpm_pkg::t_sq_ctl i_ctl,
    input  logic [W-1:0]     i_a,
    input  logic [W-1:0]     i_b,
    output logic [2*W-1:0]   o_sq
);
    logic [W-1:0]   diff;
    logic [2*W-1:0] r_sq;

    assign diff = (i_a > i_b) ? (i_a - i_b) : (i_b - i_a);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_sq <= diff * diff;
        end
    end

    assign o_sq = r_sq;
endmodule

[rtl/greedy_point_merge.sv]
`timescale 1ns / 1ps
// Order: N loaded points take up to about N*N/2 sort moves, then the merge pass
// makes pairwise compares, paced by the single point memory read port and the shared
// squaring unit; clusters are emitted last. Throughput: one set at a time; points load
// one a cycle, then ready drops.
// Reset: synchronous, active low; registers return to min_count 1, radius 10.
// ----------------------------------------------------------------------------
// greedy_point_merge
// Loads, sorts, merges points within radius, ranks clusters; presorted skips sorting.
// ----------------------------------------------------------------------------
`include "greedy_point_merge_assert.svh"
module greedy_point_merge #(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [COORD_BITS-1:0]       i_point_x,
    input  logic [COORD_BITS-1:0]       i_point_y,
    input  logic                        i_last_point,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [COORD_BITS-1:0]       o_rep_x,
    output logic [COORD_BITS-1:0]       o_rep_y,
    output logic [gpm_pkg::MINC_W-1:0]  o_member_count,
    output logic                        o_found,
    output logic                        o_end_of_list,
    output logic                        o_points_dropped,
    input  logic                        i_cfg_we,
    input  logic [gpm_pkg::CIDX_W-1:0]  i_cfg_idx,
    input  logic [gpm_pkg::CFG_W-1:0]   i_cfg_data
);
    localparam int IW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int CB  = COORD_BITS;
    localparam int WW  = CW + 2 * CB;
    localparam int OPW = (CB > gpm_pkg::RAD_W) ? CB : gpm_pkg::RAD_W;
    localparam int SW  = 2 * OPW + 1;
    localparam int MW  = (CW > gpm_pkg::MINC_W) ? CW : gpm_pkg::MINC_W;

    localparam logic [3:0] S_LOAD = 4'd0;
    localparam logic [3:0] S_SI   = 4'd1;
    localparam logic [3:0] S_SK   = 4'd2;
    localparam logic [3:0] S_SC   = 4'd3;
    localparam logic [3:0] S_SW   = 4'd4;
    localparam logic [3:0] C_INIT = 4'd5;
    localparam logic [3:0] C_R2   = 4'd6;
    localparam logic [3:0] C_OI   = 4'd7;
    localparam logic [3:0] C_OK   = 4'd8;
    localparam logic [3:0] C_JR   = 4'd9;
    localparam logic [3:0] C_M1   = 4'd10;
    localparam logic [3:0] C_M2   = 4'd11;
    localparam logic [3:0] C_CMP  = 4'd12;
    localparam logic [3:0] E_RD   = 4'd13;
    localparam logic [3:0] E_CHK  = 4'd14;
    localparam logic [3:0] E_FIN  = 4'd15;

    logic [3:0]                  r_state;
    logic [gpm_pkg::MINC_W-1:0]  r_min;
    logic [gpm_pkg::RAD_W-1:0]   r_rad;
    logic                        r_pre;
    logic [CW-1:0]               r_cnt;
    logic                        r_ovf;
    logic [CW-1:0]               r_i;
    logic [CW-1:0]               r_j;
    logic [CW-1:0]               r_nc;
    logic [CW-1:0]               r_len;
    logic [CW-1:0]               r_ccnt;
    logic                        r_phase;
    logic [WW-1:0]               r_key;
    logic [WW-1:0]               r_rd;
    logic [WW-1:0]               r_pend;
    logic                        r_have;
    logic [MAX_POINTS-1:0]       r_rem;
    logic [2*OPW-1:0]            r_r2;
    logic [2*OPW-1:0]            r_sq1;
    logic [WW-1:0]               r_mem [MAX_POINTS];

    logic                        r_ovalid;
    logic [CB-1:0]               r_ox;
    logic [CB-1:0]               r_oy;
    logic [gpm_pkg::MINC_W-1:0]  r_ocnt;
    logic                        r_ofound;
    logic                        r_oeol;
    logic                        r_odrop;

    logic                        mem_we;
    logic [IW-1:0]               mem_wa;
    logic [WW-1:0]               mem_wd;
    logic                        mem_re;
    logic [IW-1:0]               mem_ra;
    gpm_pkg::t_sq_ctl            sq_ctl;
    logic [OPW-1:0]              sq_a;
    logic [OPW-1:0]              sq_b;
    logic [2*OPW-1:0]            sq;
    logic                        in_acc;
    logic                        out_busy;
    logic                        out_load;
    logic                        move;
    logic                        below;
    logic                        low_cnt;
    logic [CB-1:0]               rd_x;
    logic [CB-1:0]               rd_y;
    logic [CB-1:0]               key_x;
    logic [CB-1:0]               key_y;
    logic [CW-1:0]               rd_cnt;
    logic [CW-1:0]               cnt_inc;

    assign o_ready  = (r_state == S_LOAD);
    assign in_acc   = i_valid && o_ready;
    assign out_busy = r_ovalid && !i_ready;
    assign out_load = ((r_state == E_CHK) && !low_cnt && r_have && !out_busy) ||
                      ((r_state == E_FIN) && !out_busy);
    assign rd_y     = r_rd[CB-1:0];
    assign rd_x     = r_rd[2*CB-1:CB];
    assign rd_cnt   = r_rd[WW-1:2*CB];
    assign key_y    = r_key[CB-1:0];
    assign key_x    = r_key[2*CB-1:CB];
    assign move     = r_phase ? (r_key > r_rd) : (r_key < r_rd);
    assign below    = (SW'(r_sq1) + SW'(sq)) < SW'(r_r2);
    assign low_cnt  = MW'(rd_cnt) < MW'(r_min);
    assign cnt_inc  = CW'(r_cnt + 1'b1);

    gpm_sqdiff #(
        .W (OPW)
    ) u_sqdiff (
        .i_clk (i_clk),
        .i_ctl (sq_ctl),
        .i_a   (sq_a),
        .i_b   (sq_b),
        .o_sq  (sq)
    );

    always_comb begin
        mem_we    = 1'b0;
        mem_wa    = '0;
        mem_wd    = '0;
        mem_re    = 1'b0;
        mem_ra    = '0;
        sq_ctl.en = 1'b0;
        sq_a      = '0;
        sq_b      = '0;
        unique case (r_state)
            S_LOAD: begin
                mem_we = in_acc && (r_cnt < CW'(MAX_POINTS));
                mem_wa = r_cnt[IW-1:0];
                mem_wd = {{CW{1'b0}}, i_point_x, i_point_y};
            end
            S_SI: begin
                mem_re = r_i < r_len;
                mem_ra = r_i[IW-1:0];
            end
            S_SK: begin
                mem_re = 1'b1;
                mem_ra = IW'(r_i - 1'b1);
            end
            S_SC: begin
                mem_we = 1'b1;
                mem_wa = r_j[IW-1:0];
                if (move) begin
                    mem_wd = r_rd;
                    mem_re = (r_j != CW'(1));
                    mem_ra = IW'(r_j - CW'(2));
                end else begin
                    mem_wd = r_key;
                end
            end
            S_SW: begin
                mem_we = 1'b1;
                mem_wa = r_j[IW-1:0];
                mem_wd = r_key;
            end
            C_INIT: begin
                sq_ctl.en = 1'b1;
                sq_a      = OPW'(r_rad);
            end
            C_OI: begin
                mem_re = (r_i < r_cnt) && !r_rem[r_i[IW-1:0]];
                mem_ra = r_i[IW-1:0];
            end
            C_JR: begin
                if (r_j >= r_cnt) begin
                    mem_we = 1'b1;
                    mem_wa = r_nc[IW-1:0];
                    mem_wd = {r_ccnt, key_x, key_y};
                end else begin
                    mem_re = !r_rem[r_j[IW-1:0]];
                    mem_ra = r_j[IW-1:0];
                end
            end
            C_M1: begin
                sq_ctl.en = (rd_x != '0);
                sq_a      = OPW'(rd_x);
                sq_b      = OPW'(key_x);
            end
            C_M2: begin
                sq_ctl.en = 1'b1;
                sq_a      = OPW'(rd_y);
                sq_b      = OPW'(key_y);
            end
            E_RD: begin
                mem_re = r_i < r_nc;
                mem_ra = r_i[IW-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_min    <= gpm_pkg::MINC_W'(1);
            r_rad    <= gpm_pkg::RAD_W'(10);
            r_pre    <= 1'b0;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_nc     <= '0;
            r_len    <= '0;
            r_ccnt   <= '0;
            r_phase  <= 1'b0;
            r_have   <= 1'b0;
            r_rem    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    gpm_pkg::REG_MIN_COUNT: r_min <= i_cfg_data[gpm_pkg::MINC_W-1:0];
                    gpm_pkg::REG_RADIUS:    r_rad <= i_cfg_data[gpm_pkg::RAD_W-1:0];
                    gpm_pkg::REG_PRESORTED: r_pre <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (r_cnt < CW'(MAX_POINTS)) begin
                            r_cnt <= cnt_inc;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last_point) begin
                            r_len   <= (r_cnt < CW'(MAX_POINTS)) ? cnt_inc : r_cnt;
                            r_phase <= 1'b0;
                            r_i     <= CW'(1);
                            r_state <= r_pre ? C_INIT : S_SI;
                        end
                    end
                end
                S_SI: begin
                    if (r_i >= r_len) begin
                        r_i    <= '0;
                        r_have <= 1'b0;
                        r_state <= r_phase ? E_RD : C_INIT;
                    end else begin
                        r_state <= S_SK;
                    end
                end
                S_SK: begin
                    r_key   <= r_rd;
                    r_j     <= r_i;
                    r_state <= S_SC;
                end
                S_SC: begin
                    if (move) begin
                        r_j <= CW'(r_j - 1'b1);
                        if (r_j == CW'(1)) begin
                            r_state <= S_SW;
                        end
                    end else begin
                        r_i     <= CW'(r_i + 1'b1);
                        r_state <= S_SI;
                    end
                end
                S_SW: begin
                    r_i     <= CW'(r_i + 1'b1);
                    r_state <= S_SI;
                end
                C_INIT: begin
                    r_rem   <= '0;
                    r_nc    <= '0;
                    r_state <= C_R2;
                end
                C_R2: begin
                    r_r2    <= sq;
                    r_i     <= '0;
                    r_state <= C_OI;
                end
                C_OI: begin
                    if (r_i >= r_cnt) begin
                        r_phase <= 1'b1;
                        r_len   <= r_nc;
                        r_have  <= 1'b0;
                        if (r_pre) begin
                            r_i     <= '0;
                            r_state <= E_RD;
                        end else begin
                            r_i     <= CW'(1);
                            r_state <= S_SI;
                        end
                    end else if (r_rem[r_i[IW-1:0]]) begin
                        r_i <= CW'(r_i + 1'b1);
                    end else begin
                        r_state <= C_OK;
                    end
                end
                C_OK: begin
                    if (rd_x == '0) begin
                        r_i     <= CW'(r_i + 1'b1);
                        r_state <= C_OI;
                    end else begin
                        r_key   <= r_rd;
                        r_ccnt  <= CW'(1);
                        r_j     <= CW'(r_i + 1'b1);
                        r_state <= C_JR;
                    end
                end
                C_JR: begin
                    if (r_j >= r_cnt) begin
                        r_nc    <= CW'(r_nc + 1'b1);
                        r_i     <= CW'(r_i + 1'b1);
                        r_state <= C_OI;
                    end else if (r_rem[r_j[IW-1:0]]) begin
                        r_j <= CW'(r_j + 1'b1);
                    end else begin
                        r_state <= C_M1;
                    end
                end
                C_M1: begin
                    if (rd_x == '0) begin
                        r_j     <= CW'(r_j + 1'b1);
                        r_state <= C_JR;
                    end else begin
                        r_state <= C_M2;
                    end
                end
                C_M2: begin
                    r_sq1   <= sq;
                    r_state <= C_CMP;
                end
                C_CMP: begin
                    if (below) begin
                        r_rem[r_j[IW-1:0]] <= 1'b1;
                        r_ccnt             <= CW'(r_ccnt + 1'b1);
                    end
                    r_j     <= CW'(r_j + 1'b1);
                    r_state <= C_JR;
                end
                E_RD: begin
                    r_state <= (r_i < r_nc) ? E_CHK : E_FIN;
                end
                E_CHK: begin
                    if (low_cnt) begin
                        r_state <= E_FIN;
                    end else if (!(r_have && out_busy)) begin
                        if (r_have) begin
                            r_ox     <= r_pend[2*CB-1:CB];
                            r_oy     <= r_pend[CB-1:0];
                            r_ocnt   <= gpm_pkg::MINC_W'(r_pend[WW-1:2*CB]);
                            r_ofound <= 1'b1;
                            r_oeol   <= 1'b0;
                            r_odrop  <= r_ovf;
                        end
                        r_pend  <= r_rd;
                        r_have  <= 1'b1;
                        r_i     <= CW'(r_i + 1'b1);
                        r_state <= E_RD;
                    end
                end
                E_FIN: begin
                    if (!out_busy) begin
                        r_ox     <= r_have ? r_pend[2*CB-1:CB] : '0;
                        r_oy     <= r_have ? r_pend[CB-1:0] : '0;
                        r_ocnt   <= r_have ? gpm_pkg::MINC_W'(r_pend[WW-1:2*CB]) : '0;
                        r_ofound <= r_have;
                        r_oeol   <= 1'b1;
                        r_odrop  <= r_ovf;
                        r_cnt    <= '0;
                        r_ovf    <= 1'b0;
                        r_nc     <= '0;
                        r_state  <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_valid          = r_ovalid;
    assign o_rep_x          = r_ox;
    assign o_rep_y          = r_oy;
    assign o_member_count   = r_ocnt;
    assign o_found          = r_ofound;
    assign o_end_of_list    = r_oeol;
    assign o_points_dropped = r_odrop;

    `GPM_ASSERT_IMP(a_nc_le_cnt, i_clk, i_rst_n, 1'b1, r_nc <= r_cnt)
    `GPM_ASSERT_IMP(a_cmp_order, i_clk, i_rst_n, r_state == C_CMP, r_j > r_i)
    `GPM_ASSERT_NXT(a_ovf_set, i_clk, i_rst_n, in_acc && (r_cnt == CW'(MAX_POINTS)), r_ovf)
endmodule

[dv/tb_greedy_point_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_greedy_point_merge
// Drives point sets into the merge block under several register settings,
// predicts the cluster list of each set, ranked unless presorted, and checks every result.
// ----------------------------------------------------------------------------
module tb_greedy_point_merge;
    localparam int NPTS  = 32;
    localparam int CB    = 12;
    localparam int WDOG  = 400000;

    typedef struct packed {
        logic [CB-1:0]              rx;
        logic [CB-1:0]              ry;
        logic [gpm_pkg::MINC_W-1:0] cnt;
        logic                       fnd;
        logic                       eol;
        logic                       drop;
    } t_cluster_res;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_ready;
    logic [CB-1:0]                i_point_x = '0;
    logic [CB-1:0]                i_point_y = '0;
    logic                         i_last_point = 1'b0;
    logic                         o_valid;
    logic                         i_ready = 1'b0;
    logic [CB-1:0]                o_rep_x;
    logic [CB-1:0]                o_rep_y;
    logic [gpm_pkg::MINC_W-1:0]   o_member_count;
    logic                         o_found;
    logic                         o_end_of_list;
    logic                         o_points_dropped;
    logic                         i_cfg_we = 1'b0;
    logic [gpm_pkg::CIDX_W-1:0]   i_cfg_idx = '0;
    logic [gpm_pkg::CFG_W-1:0]    i_cfg_data = '0;

    greedy_point_merge i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [gpm_pkg::MINC_W-1:0] min_count_q = 6'd1;
    logic [gpm_pkg::RAD_W-1:0]  radius_q = 12'd10;
    logic                       presorted_q = 1'b0;
    logic [CB-1:0]              pts_x[NPTS];
    logic [CB-1:0]              pts_y[NPTS];
    int                         n_loaded = 0;
    logic                       overflow = 1'b0;
    t_cluster_res               expected_clusters[$];
    int                         mismatches = 0;
    int                         idle_cycles = 0;
    bit                         no_idle = 1'b0;

    function automatic bit pt_before(logic [CB-1:0] ax, logic [CB-1:0] ay,
                                     logic [CB-1:0] bx, logic [CB-1:0] by);
        return ax < bx || (ax == bx && ay < by);
    endfunction

    task automatic predict_point(logic [CB-1:0] x, logic [CB-1:0] y, logic last);
        int           cm[NPTS];
        int           cp[NPTS];
        bit           live[NPTS];
        int           nc, j, km, kp, emitted;
        logic [CB-1:0] kx, ky;
        longint       r2, dx, dy;
        t_cluster_res r;
        if (n_loaded < NPTS) begin
            pts_x[n_loaded] = x;
            pts_y[n_loaded] = y;
            n_loaded++;
        end else begin
            overflow = 1'b1;
        end
        if (!last) return;
        if (!presorted_q) begin
            for (int i = 1; i < n_loaded; i++) begin
                kx = pts_x[i];
                ky = pts_y[i];
                j = i;
                while (j > 0 && pt_before(kx, ky, pts_x[j-1], pts_y[j-1])) begin
                    pts_x[j] = pts_x[j-1];
                    pts_y[j] = pts_y[j-1];
                    j--;
                end
                pts_x[j] = kx;
                pts_y[j] = ky;
            end
        end
        r2 = longint'(radius_q) * longint'(radius_q);
        for (int i = 0; i < n_loaded; i++) live[i] = pts_x[i] != 0;
        nc = 0;
        for (int i = 0; i < n_loaded; i++) begin
            if (live[i]) begin
                cp[nc] = i;
                cm[nc] = 1;
                for (int k = i + 1; k < n_loaded; k++) begin
                    if (live[k]) begin
                        dx = longint'(pts_x[i]) - longint'(pts_x[k]);
                        dy = longint'(pts_y[i]) - longint'(pts_y[k]);
                        if (dx * dx + dy * dy < r2) begin
                            live[k] = 1'b0;
                            cm[nc]++;
                        end
                    end
                end
                nc++;
            end
        end
        if (!presorted_q) begin
            for (int i = 1; i < nc; i++) begin
                km = cm[i];
                kp = cp[i];
                j = i;
                while (j > 0 && (km != cm[j-1] ? km > cm[j-1] :
                       pt_before(pts_x[cp[j-1]], pts_y[cp[j-1]], pts_x[kp], pts_y[kp])))
                begin
                    cm[j] = cm[j-1];
                    cp[j] = cp[j-1];
                    j--;
                end
                cm[j] = km;
                cp[j] = kp;
            end
        end
        emitted = 0;
        for (int i = 0; i < nc; i++) begin
            if (cm[i] < min_count_q) break;
            r.rx = pts_x[cp[i]];
            r.ry = pts_y[cp[i]];
            r.cnt = cm[i][gpm_pkg::MINC_W-1:0];
            r.fnd = 1'b1;
            r.eol = (i == nc - 1) || (cm[i+1] < min_count_q);
            r.drop = overflow;
            expected_clusters = {expected_clusters, r};
            emitted++;
        end
        if (emitted == 0) begin
            r = '0;
            r.eol = 1'b1;
            r.drop = overflow;
            expected_clusters = {expected_clusters, r};
        end
        n_loaded = 0;
        overflow = 1'b0;
    endtask

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 29);
    endfunction

    always @(posedge i_clk) begin
        i_ready <= !idle_now();
    end

    always @(posedge i_clk) begin
        t_cluster_res got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_rep_x, o_rep_y, o_member_count, o_found, o_end_of_list,
                    o_points_dropped};
            if (expected_clusters.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d cnt=%0d",
                             got.rx, got.ry, got.cnt);
            end else begin
                want = expected_clusters.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp x=%0d y=%0d c=%0d f=%0b e=%0b d=%0b %s",
                                 want.rx, want.ry, want.cnt, want.fnd, want.eol,
                                 want.drop, $sformatf("act x=%0d y=%0d c=%0d f=%0b e=%0b d=%0b",
                                 got.rx, got.ry, got.cnt, got.fnd, got.eol, got.drop));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_point(logic [CB-1:0] x, logic [CB-1:0] y, logic last);
        while (idle_now()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_point_x <= x;
        i_point_y <= y;
        i_last_point <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_point(x, y, last);
        if (last) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        while (expected_clusters.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [gpm_pkg::CIDX_W-1:0] idx,
                             logic [gpm_pkg::CFG_W-1:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            gpm_pkg::REG_MIN_COUNT: min_count_q = val[gpm_pkg::MINC_W-1:0];
            gpm_pkg::REG_RADIUS:    radius_q = val[gpm_pkg::RAD_W-1:0];
            default:                presorted_q = val[0];
        endcase
    endtask

    task automatic set_config(int mc, int rad, bit ps);
        write_reg(gpm_pkg::REG_MIN_COUNT, gpm_pkg::CFG_W'(mc));
        write_reg(gpm_pkg::REG_RADIUS, gpm_pkg::CFG_W'(rad));
        write_reg(gpm_pkg::REG_PRESORTED, gpm_pkg::CFG_W'(ps));
    endtask

    task automatic send_random_set(int n, int spread);
        logic [CB-1:0] cx, cy, x, y;
        cx = CB'($urandom);
        cy = CB'($urandom);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) begin
                x = ($urandom_range(3) == 0) ? '0 : CB'($urandom);
                y = CB'($urandom);
            end else begin
                x = cx + CB'($urandom_range(2 * spread)) - CB'(spread);
                y = cy + CB'($urandom_range(2 * spread)) - CB'(spread);
                if ($urandom_range(7) == 0) begin
                    cx = CB'($urandom);
                    cy = CB'($urandom);
                end
            end
            send_point(x, y, i == n - 1);
        end
    endtask

    task automatic test_directed();
        send_point(12'd100, 12'd100, 1'b0);
        send_point(12'd100, 12'd100, 1'b0);
        send_point(12'd0, 12'd105, 1'b0);
        send_point(12'd105, 12'd100, 1'b0);
        send_point(12'd4095, 12'd4095, 1'b0);
        send_point(12'd4095, 12'd0, 1'b1);
        send_point(12'd0, 12'd0, 1'b1);
        send_point(12'd1, 12'd4095, 1'b1);
        set_config(0, 0, 0);
        send_point(12'd7, 12'd7, 1'b0);
        send_point(12'd7, 12'd7, 1'b1);
        set_config(32, 4095, 0);
        send_point(12'd1, 12'd1, 1'b0);
        send_point(12'd4095, 12'd4095, 1'b1);
    endtask

    task automatic test_overflow();
        set_config(2, 4095, 0);
        for (int i = 0; i < 34; i++) send_point(12'd50, CB'(i), 1'b0);
        send_point(12'd50, 12'd1, 1'b1);
        set_config(1, 1, 1);
        for (int i = 0; i < 32; i++) send_point(CB'(i + 1), CB'(i), i == 31);
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 400) begin
            int n;
            if ($urandom_range(7) == 0)
                set_config($urandom_range(4), $urandom_range(40),
                           bit'($urandom_range(1)));
            n = ($urandom_range(15) == 0) ? 34 : $urandom_range(1, 12);
            no_idle = (sent >= 200 && sent < 260);
            send_random_set(n, $urandom_range(1, 30));
            sent += n;
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_overflow();
        test_random();
        set_config(1, 10, 0);
        send_random_set(5, 5);
        drain();
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

[greedy_point_merge.f]
+incdir+rtl
rtl/gpm_pkg.sv
rtl/gpm_sqdiff.sv
rtl/greedy_point_merge.sv
dv/tb_greedy_point_merge.sv
